FILE: src/bba_pkg.sv
package bba_pkg;

  localparam int MAX_BITS  = 4096;
  localparam int IDX_W     = 12;
  localparam int CNT_W     = 13;
  localparam int WORD_BITS = 64;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ROWS      = MAX_BITS / WORD_BITS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int GRP_BITS  = 8;
  localparam int GRPS      = WORD_BITS / GRP_BITS;
  localparam int GRP_W     = $clog2(GRP_BITS);

  localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = CNT_W'(4096);
  localparam logic [CNT_W-1:0] MAP_LIMIT         = CNT_W'(MAX_BITS);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_BLOCK_COUNT = 1'b0;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] free_idx;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] alloc_index;
    status_t          status;
  } rsp_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] pos;
  } zfind_t;

endpackage

FILE: src/bba_find_zero.sv
module bba_find_zero
  import bba_pkg::*;
(
  input  logic [WORD_BITS-1:0] bits,
  output zfind_t               res
);

  logic [GRPS-1:0]  grp_has;
  logic [GRP_W-1:0] grp_pos [GRPS];

  // lowest clear bit within each byte-sized group
  always_comb begin
    for (int g = 0; g < GRPS; g++) begin
      grp_has[g] = 1'b0;
      grp_pos[g] = '0;
      for (int b = GRP_BITS - 1; b >= 0; b--) begin
        if (!bits[g*GRP_BITS + b]) begin
          grp_has[g] = 1'b1;
          grp_pos[g] = GRP_W'(b);
        end
      end
    end
  end

  // then the lowest group that has one
  always_comb begin
    res = '0;
    for (int g = GRPS - 1; g >= 0; g--) begin
      if (grp_has[g]) begin
        res.found = 1'b1;
        res.pos   = {(BIT_W-GRP_W)'(g), grp_pos[g]};
      end
    end
  end

endmodule

FILE: src/block_bitmap_allocator.sv
// Each accepted request beat passes through S_IDLE (accept), S_ADDR (row select
// and map read) and S_MOD (modify and write-back) before its response beat.
// A new request is taken only back in S_IDLE, after the read-modify-write of the
// single-port bitmap memory; a held response keeps the block in S_MOD while stalled.
// Reset: all row-valid and row-full flags cleared, so every block reads free
// at once with no clearing pass; block_count returns to 4096.
module block_bitmap_allocator
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        req_valid,
  output logic        req_stall,
  input  req_t        req,

  output logic        rsp_valid,
  input  logic        rsp_stall,
  output rsp_t        rsp,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADDR,
    S_MOD
  } state_t;

  state_t             state;
  req_t               item;
  logic [ROW_W-1:0]   row;
  logic               fail_early;
  logic [CNT_W-1:0]   block_count;

  logic [WORD_BITS-1:0] mem [ROWS];
  logic [WORD_BITS-1:0] rdata;
  logic [ROWS-1:0]      row_valid;
  logic [ROWS-1:0]      row_full;

  logic [CNT_W-1:0]     lim;
  zfind_t               sum_find;
  zfind_t               word_find;
  logic                 alloc_none;
  logic                 free_bad;
  logic [ROW_W-1:0]     rd_row;
  logic                 is_alloc;

  logic [WORD_BITS-1:0] cur_word;
  logic [WORD_BITS-1:0] new_word;
  logic [WORD_BITS-1:0] bit_mask;
  logic [BIT_W-1:0]     bit_pos;
  logic [IDX_W-1:0]     new_idx;
  logic                 alloc_ok;
  logic                 go;
  logic                 do_write;
  rsp_t                 rsp_next;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_BLOCK_COUNT) ? {{(32-CNT_W){1'b0}}, block_count} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_BLOCK_COUNT) begin
      block_count <= pwdata[CNT_W-1:0];
    end
  end

  assign lim = (block_count > MAP_LIMIT) ? MAP_LIMIT : block_count;

  assign req_stall = (state != S_IDLE);
  assign is_alloc  = (item.cmd == CMD_ALLOC);

  // row select: lowest row with a clear bit, or the row of the block to free
  bba_find_zero u_sum_find (
    .bits (row_full),
    .res  (sum_find)
  );

  assign alloc_none = !sum_find.found || ({1'b0, sum_find.pos, {BIT_W{1'b0}}} >= lim);
  assign free_bad   = ({1'b0, item.free_idx} >= lim);
  assign rd_row     = is_alloc ? sum_find.pos : item.free_idx[IDX_W-1:BIT_W];

  // modify
  assign cur_word = row_valid[row] ? rdata : '0;

  bba_find_zero u_word_find (
    .bits (cur_word),
    .res  (word_find)
  );

  assign new_idx  = {row, word_find.pos};
  assign alloc_ok = !fail_early && word_find.found && ({1'b0, new_idx} < lim);
  assign bit_pos  = is_alloc ? word_find.pos : item.free_idx[BIT_W-1:0];
  assign bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_pos;
  assign new_word = is_alloc ? (cur_word | bit_mask) : (cur_word & ~bit_mask);

  assign go       = (state == S_MOD) && (!rsp_valid || !rsp_stall);
  assign do_write = go && (is_alloc ? alloc_ok : !fail_early);

  always_comb begin
    rsp_next = '0;
    if (is_alloc) begin
      if (alloc_ok) begin
        rsp_next.alloc_index = new_idx;
        rsp_next.status      = ST_OK;
      end else begin
        rsp_next.status      = ST_FULL;
      end
    end else begin
      rsp_next.status = fail_early ? ST_RANGE : ST_OK;
    end
  end

  // bitmap memory
  always_ff @(posedge clk) begin
    if (state == S_ADDR) begin
      rdata <= mem[rd_row];
    end
    if (do_write) begin
      mem[row] <= new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      row_full  <= '0;
    end else if (do_write) begin
      row_valid[row] <= 1'b1;
      row_full[row]  <= &new_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            item  <= req;
            state <= S_ADDR;
          end
        end
        S_ADDR: begin
          row        <= rd_row;
          fail_early <= is_alloc ? alloc_none : free_bad;
          state      <= S_MOD;
        end
        S_MOD: begin
          if (go) begin
            rsp   <= rsp_next;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // an allocation sets exactly one more bit in its row
  a_alloc_one_bit: assert property (@(posedge clk) disable iff (rst)
    (do_write && is_alloc) |-> ($countones(new_word) == $countones(cur_word) + 1))
    else $error("allocation did not set exactly one bit");

  // a granted block always lies below the active limit
  a_alloc_in_range: assert property (@(posedge clk) disable iff (rst)
    (go && is_alloc && alloc_ok) |-> ({1'b0, new_idx} < lim))
    else $error("allocated block beyond limit");

  // a failed request never touches the map
  a_fail_no_write: assert property (@(posedge clk) disable iff (rst)
    (go && rsp_next.status != ST_OK) |-> !do_write)
    else $error("map written on failed request");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!rsp_valid && state == S_IDLE && row_valid == '0))
    else $error("reset left control state set");

endmodule

FILE: test/bba_checker.sv
module bba_checker
  import bba_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        req_valid,
  input  logic        req_stall,
  input  req_t        req,

  input  logic        rsp_valid,
  input  logic        rsp_stall,
  input  rsp_t        rsp,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic [31:0] prdata,
  input  logic        pready,

  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] BLOCK_COUNT_ADDR = 3'(4 * REG_BLOCK_COUNT);
  localparam int         INDEX_REACH      = 1 << IDX_W;

  logic [MAX_BITS-1:0] block_used;
  logic [CNT_W-1:0]    managed_blocks;
  rsp_t                expected_rsp[$];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // count saturates at the map size and at what a 12-bit index can address
  function automatic int active_blocks();
    int n;
    n = int'(managed_blocks);
    if (n > MAX_BITS) n = MAX_BITS;
    if (n > INDEX_REACH) n = INDEX_REACH;
    return n;
  endfunction

  function automatic rsp_t predict_rsp(req_t r);
    rsp_t res;
    int   lim;
    bit   found;
    lim             = active_blocks();
    res.alloc_index = '0;
    res.status      = ST_OK;
    found           = 1'b0;
    if (r.cmd == CMD_ALLOC) begin
      for (int i = 0; i < lim && !found; i++) begin
        if (!block_used[i]) begin
          block_used[i]   = 1'b1;
          res.alloc_index = IDX_W'(i);
          found           = 1'b1;
        end
      end
      if (!found) res.status = ST_FULL;
    end else if (int'(r.free_idx) < lim) begin
      // freeing a free block is fine and reports ok
      block_used[r.free_idx] = 1'b0;
    end else begin
      res.status = ST_RANGE;
    end
    return res;
  endfunction

  task automatic flag(input string what);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      block_used     = '0;
      managed_blocks = BLOCK_COUNT_RESET;
      expected_rsp.delete();
    end else begin
      // response first: a request taken at this edge cannot be answered at it
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsp.size() == 0) begin
          flag($sformatf("unexpected response beat: alloc_index %0d status %0d",
                         rsp.alloc_index, rsp.status));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.alloc_index !== want.alloc_index || rsp.status !== want.status) begin
            flag($sformatf("mismatch: alloc_index exp %0d got %0d, status exp %0d got %0d",
                           want.alloc_index, rsp.alloc_index, want.status, rsp.status));
          end
        end
      end
      if (req_valid && !req_stall) expected_rsp.push_back(predict_rsp(req));
      if (psel && penable && pready && paddr == BLOCK_COUNT_ADDR) begin
        if (pwrite) begin
          managed_blocks = pwdata[CNT_W-1:0];
        end else if (prdata !== 32'(managed_blocks)) begin
          flag($sformatf("block_count read: exp %0d got %0d", managed_blocks, prdata));
        end
      end
    end
    pending = expected_rsp.size();
  end

endmodule

FILE: test/tb_block_bitmap_allocator.sv
module tb_block_bitmap_allocator
  import bba_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] BLOCK_COUNT_ADDR = 3'(4 * REG_BLOCK_COUNT);
  localparam int RUN_LIMIT   = 400000;
  localparam int HOLD_CYCLES = 250;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 85;

  logic        clk;
  logic        rst;
  logic        req_valid;
  logic        req_stall;
  req_t        req;
  logic        rsp_valid;
  logic        rsp_stall;
  rsp_t        rsp;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int cycle_count;
  bit calm;
  bit hold_pending;

  block_bitmap_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  bba_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // mostly short gaps, a few long ones; none at all in a calm phase
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // response side: random stall runs, plus one long hold-off on request
  initial begin
    int n;
    rsp_stall = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_pending) begin
        rsp_stall <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
        hold_pending = 1'b0;
      end else if (calm || $urandom_range(0, 1)) begin
        rsp_stall <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end else begin
        rsp_stall <= 1'b1;
        repeat (1 + pick_gap()) @(posedge clk);
      end
    end
  end

  // stall is sampled at the falling edge, so it is the value seen by the next rising edge
  task automatic send_req(input logic c, input logic [IDX_W-1:0] i);
    int gap;
    bit stalled;
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      req       <= req_t'({1'($urandom), IDX_W'($urandom)});
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= req_t'({c, i});
    do begin
      @(negedge clk);
      stalled = req_stall;
      @(posedge clk);
    end while (stalled);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [31:0] v);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= BLOCK_COUNT_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdy = pready;
      @(posedge clk);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // write, then read back; upper bits of the bus are noise
  task automatic set_block_count(input logic [CNT_W-1:0] n);
    apb_access(1'b1, {(32 - CNT_W)'($urandom), n});
    apb_access(1'b0, 32'h0);
  endtask

  initial begin
    logic [CNT_W-1:0] counts [PHASES];
    logic [CNT_W-1:0] n;
    logic             c;
    logic [IDX_W-1:0] idx;
    int               ph;
    int               k;
    int               lim;
    int               roll;

    rst          = 1'b1;
    req_valid    = 1'b0;
    req          = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_pending = 1'b0;
    counts = '{13'd8191, 13'd16, 13'd1, 13'd0, 13'd64, 13'd65, 13'd4096, 13'd7, 13'd40,
               13'd200};

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // full map after reset: first fit, double free, both ends of the index
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_ALLOC, 12'd4095);
    send_req(CMD_FREE,  12'd0);
    send_req(CMD_FREE,  12'd0);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE,  12'd4095);
    send_req(CMD_FREE,  12'd2048);
    send_req(CMD_ALLOC, 12'd0);
    drain();

    // no blocks at all
    set_block_count(13'd0);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE,  12'd0);
    send_req(CMD_FREE,  12'd4095);
    drain();

    // shrunk to three: map full, just past the limit flagged
    set_block_count(13'd3);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE,  12'd3);
    send_req(CMD_FREE,  12'd2);
    send_req(CMD_ALLOC, 12'd0);
    drain();

    // count beyond the map saturates; old bits kept across the shrink
    set_block_count(13'd8191);
    send_req(CMD_ALLOC, 12'd0);
    send_req(CMD_FREE,  12'd4095);
    send_req(CMD_ALLOC, 12'hAAA);
    drain();

    for (ph = 0; ph < PHASES; ph++) begin
      n = (ph == PHASES - 1) ? CNT_W'($urandom_range(2, 300)) : counts[ph];
      set_block_count(n);
      lim  = (int'(n) > MAX_BITS) ? MAX_BITS : int'(n);
      calm = (ph == 2 || ph == 4);
      // long receiver hold-off while requests keep coming back to back
      if (ph == 4) hold_pending = 1'b1;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        c    = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
        roll = $urandom_range(0, 99);
        if (lim > 0 && roll < 70) idx = IDX_W'($urandom_range(0, lim - 1));
        else if (roll < 85) idx = IDX_W'(lim + $urandom_range(0, 2) - 1);
        else idx = IDX_W'($urandom);
        send_req(c, idx);
      end
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
